### hw/rtl/dqm_pkg.sv
// Shared types and constants for the dual quaternion to matrix pipeline.
`timescale 1ns / 1ps

package dqm_pkg;

  // Quotient bits produced by each divider lane (covers the Q11.8 range).
  localparam int QW = 20;
  // Divisor width: the squared norm reaches 2^32.
  localparam int DW = 33;
  // Dividend width: a 33-bit magnitude shifted left by up to 15.
  localparam int NW = 48;
  // Width of signed sums of products.
  localparam int SW = 35;
  // Register stages inside one divider lane: range check plus one per quotient bit.
  localparam int LANE_ST = QW + 1;
  // Rotation lanes first, then translation lanes.
  localparam int ROT_LANES = 9;
  localparam int LANES = 12;
  // Number of products formed in the first stage.
  localparam int NPROD = 22;

  localparam int ROT_SHIFT = 14;
  localparam int TR_SHIFT = 15;

  localparam logic [DW-1:0] NORM_THRESHOLD = DW'(268);
  localparam logic [15:0] ROT_ONE = 16'd16384;
  localparam logic [QW:0] TR_POS_LIM = (QW+1)'(524287);
  localparam logic [QW:0] TR_NEG_LIM = (QW+1)'(524288);

  typedef struct packed {
    logic signed [15:0] real_w;
    logic signed [15:0] real_x;
    logic signed [15:0] real_y;
    logic signed [15:0] real_z;
    logic signed [15:0] dual_w;
    logic signed [15:0] dual_x;
    logic signed [15:0] dual_y;
    logic signed [15:0] dual_z;
  } dqm_in_t;

  typedef struct packed {
    logic signed [15:0] rot_c0_x;
    logic signed [15:0] rot_c0_y;
    logic signed [15:0] rot_c0_z;
    logic signed [15:0] rot_c1_x;
    logic signed [15:0] rot_c1_y;
    logic signed [15:0] rot_c1_z;
    logic signed [15:0] rot_c2_x;
    logic signed [15:0] rot_c2_y;
    logic signed [15:0] rot_c2_z;
    logic signed [19:0] trans_x;
    logic signed [19:0] trans_y;
    logic signed [19:0] trans_z;
  } dqm_out_t;

  // Result of one divider lane, before rounding and saturation.
  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic          rnd;
    logic [QW-1:0] quo;
  } dqm_quo_t;

endpackage

### hw/rtl/dqm_lane.sv
// Pipelined restoring divider lane: one quotient bit per register stage.
`timescale 1ns / 1ps

module dqm_lane (
  input  logic                           clk_i,
  input  logic [dqm_pkg::LANE_ST-1:0]    en_i,
  input  logic [dqm_pkg::NW-1:0]         dvd_i,
  input  logic [dqm_pkg::DW-1:0]         dvs_i,
  input  logic                           neg_i,
  output dqm_pkg::dqm_quo_t              quo_o
);
  import dqm_pkg::*;

  logic [DW-1:0] rem_q [LANE_ST];
  logic [QW-1:0] low_q [LANE_ST];
  logic [QW-1:0] quo_q [LANE_ST];
  logic [DW-1:0] dvs_q [LANE_ST];
  logic          neg_q [LANE_ST];
  logic          ovf_q [LANE_ST];

  logic [DW-1:0] hi_ext;
  logic          ovf_d;

  // Quotient above QW bits means saturation; otherwise the top part is the first remainder.
  assign hi_ext = {{(DW-(NW-QW)){1'b0}}, dvd_i[NW-1:QW]};
  assign ovf_d  = (hi_ext >= dvs_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= ovf_d ? '0 : hi_ext;
      low_q[0] <= dvd_i[QW-1:0];
      quo_q[0] <= '0;
      dvs_q[0] <= dvs_i;
      neg_q[0] <= neg_i;
      ovf_q[0] <= ovf_d;
    end
  end

  for (genvar j = 1; j < LANE_ST; j++) begin : g_step
    localparam int B = QW - j;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_q[j-1], low_q[j-1][B]};
    assign diff  = trial - {1'b0, dvs_q[j-1]};
    assign ge    = (trial >= {1'b0, dvs_q[j-1]});

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low_q[j] <= low_q[j-1];
        quo_q[j] <= quo_q[j-1] | (ge ? (QW'(1) << B) : '0);
        dvs_q[j] <= dvs_q[j-1];
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  // Round half away from zero: bump when twice the remainder reaches the divisor.
  assign quo_o.neg = neg_q[LANE_ST-1];
  assign quo_o.ovf = ovf_q[LANE_ST-1];
  assign quo_o.rnd = ({rem_q[LANE_ST-1], 1'b0} >= {1'b0, dvs_q[LANE_ST-1]});
  assign quo_o.quo = quo_q[LANE_ST-1];

endmodule

### hw/rtl/dual_quaternion_to_matrix_top.sv
// Top level: dual quaternion to 3x4 rigid transform, fully pipelined.
`timescale 1ns / 1ps

// Usage
//   Request channel: in_valid_i / in_ready_o carry one dual quaternion in
//   in_req_i (real part Q2.14, dual part Q8.8). Response channel:
//   out_valid_o / out_ready_i carry the rotation columns (Q2.14, clamped to
//   +/-1) and the translation (Q11.8, clamped) in out_rsp_o.
//   Pipeline: 25 register stages: three arithmetic stages (products, sums,
//   magnitude prep), the 21-stage divider lanes (range check plus one
//   quotient bit per stage) and the output register that rounds and clamps.
//   The accepting edge loads the first stage; out_valid_o rises once the
//   request has passed through every stage into the output register.
//   Throughput: one request per cycle while the receiver takes responses.
//   Each stage holds a valid bit; a stage loads whenever it is empty or the
//   stage after it moves, so bubbles collapse under back-pressure.
//   When out_ready_i is low the response holds; earlier stages keep filling
//   until the pipeline is full, then in_ready_o drops. Nothing is dropped
//   or repeated.
//   A squared norm at or below the threshold gives the identity rotation and
//   zero translation.
//   Reset clears all valid bits; data registers are not reset.
module dual_quaternion_to_matrix_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dqm_pkg::dqm_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dqm_pkg::dqm_out_t out_rsp_o
);
  import dqm_pkg::*;

  // Stage map: 0 products, 1 sums, 2 prep, 3..23 divider lanes, 24 output.
  localparam int ST_LANE = 3;
  localparam int NST = ST_LANE + LANE_ST + 1;

  logic [NST-1:0] v_q;
  logic [NST:0]   en;

  // Advance a stage when it is empty or the next stage advances.
  always_comb begin
    en[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---- stage 0: products ----
  logic signed [31:0] m_q [NPROD];
  logic signed [15:0] w, x, y, z, dw, dx, dy, dz;

  assign w  = in_req_i.real_w;
  assign x  = in_req_i.real_x;
  assign y  = in_req_i.real_y;
  assign z  = in_req_i.real_z;
  assign dw = in_req_i.dual_w;
  assign dx = in_req_i.dual_x;
  assign dy = in_req_i.dual_y;
  assign dz = in_req_i.dual_z;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      m_q[0]  <= w * w;
      m_q[1]  <= x * x;
      m_q[2]  <= y * y;
      m_q[3]  <= z * z;
      m_q[4]  <= x * y;
      m_q[5]  <= w * z;
      m_q[6]  <= x * z;
      m_q[7]  <= w * y;
      m_q[8]  <= y * z;
      m_q[9]  <= w * x;
      m_q[10] <= w * dx;
      m_q[11] <= dw * x;
      m_q[12] <= dy * z;
      m_q[13] <= dz * y;
      m_q[14] <= w * dy;
      m_q[15] <= dw * y;
      m_q[16] <= dz * x;
      m_q[17] <= dx * z;
      m_q[18] <= w * dz;
      m_q[19] <= dw * z;
      m_q[20] <= dx * y;
      m_q[21] <= dy * x;
    end
  end

  // ---- stage 1: squared norm and numerators ----
  logic signed [SW-1:0] e [NPROD];
  logic signed [SW-1:0] n_q1;
  logic signed [SW-1:0] num_q1 [LANES];

  for (genvar i = 0; i < NPROD; i++) begin : g_ext
    assign e[i] = SW'(m_q[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      n_q1       <= e[0] + e[1] + e[2] + e[3];
      num_q1[0]  <= e[0] + e[1] - e[2] - e[3];
      num_q1[1]  <= (e[4] + e[5]) <<< 1;
      num_q1[2]  <= (e[6] - e[7]) <<< 1;
      num_q1[3]  <= (e[4] - e[5]) <<< 1;
      num_q1[4]  <= e[0] + e[2] - e[1] - e[3];
      num_q1[5]  <= (e[8] + e[9]) <<< 1;
      num_q1[6]  <= (e[6] + e[7]) <<< 1;
      num_q1[7]  <= (e[8] - e[9]) <<< 1;
      num_q1[8]  <= e[0] + e[3] - e[1] - e[2];
      // Vector part of dual times conjugate of real, scaled 2^-22.
      num_q1[9]  <= e[10] - e[11] - (e[12] - e[13]);
      num_q1[10] <= e[14] - e[15] - (e[16] - e[17]);
      num_q1[11] <= e[18] - e[19] - (e[20] - e[21]);
    end
  end

  // ---- stage 2: signs, magnitudes, scaled dividends ----
  logic [NW-1:0] dvd_q2 [LANES];
  logic          neg_q2 [LANES];
  logic [DW-1:0] dvs_q2;
  logic          deg_q2;

  for (genvar i = 0; i < LANES; i++) begin : g_prep
    logic          neg;
    logic [SW-1:0] absv;
    logic [DW-1:0] mag;

    assign neg  = num_q1[i][SW-1];
    assign absv = neg ? (SW'(0) - num_q1[i]) : num_q1[i];
    assign mag  = absv[DW-1:0];

    always_ff @(posedge clk_i) begin
      if (en[2]) begin
        neg_q2[i] <= neg;
        if (i < ROT_LANES) begin
          dvd_q2[i] <= NW'({mag, {ROT_SHIFT{1'b0}}});
        end else begin
          dvd_q2[i] <= NW'({mag, {TR_SHIFT{1'b0}}});
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dvs_q2 <= n_q1[DW-1:0];
      deg_q2 <= (n_q1[DW-1:0] <= NORM_THRESHOLD);
    end
  end

  // ---- stages 3..23: divider lanes ----
  dqm_quo_t quo [LANES];
  logic     deg_q [LANE_ST];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    dqm_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en[ST_LANE +: LANE_ST]),
      .dvd_i (dvd_q2[i]),
      .dvs_i (dvs_q2),
      .neg_i (neg_q2[i]),
      .quo_o (quo[i])
    );
  end

  // Carry the degenerate flag alongside the lanes.
  always_ff @(posedge clk_i) begin
    if (en[ST_LANE]) begin
      deg_q[0] <= deg_q2;
    end
    for (int j = 1; j < LANE_ST; j++) begin
      if (en[ST_LANE + j]) begin
        deg_q[j] <= deg_q[j-1];
      end
    end
  end

  // ---- stage 24: round, clamp, select identity ----
  function automatic logic [15:0] sat_rot(dqm_quo_t qv);
    logic [QW:0]  qr;
    logic [15:0]  mag;
    qr = {1'b0, qv.quo} + (QW+1)'(qv.rnd);
    if (qv.ovf || qr > (QW+1)'(ROT_ONE)) begin
      mag = ROT_ONE;
    end else begin
      mag = qr[15:0];
    end
    return qv.neg ? (16'd0 - mag) : mag;
  endfunction

  function automatic logic [19:0] sat_tr(dqm_quo_t qv);
    logic [QW:0] qr;
    logic [QW:0] lim;
    logic [QW:0] mag;
    qr  = {1'b0, qv.quo} + (QW+1)'(qv.rnd);
    lim = qv.neg ? TR_NEG_LIM : TR_POS_LIM;
    mag = (qv.ovf || qr > lim) ? lim : qr;
    return qv.neg ? 20'((QW+1)'(0) - mag) : mag[19:0];
  endfunction

  dqm_out_t rsp_d, rsp_q;
  logic     deg_l;

  assign deg_l = deg_q[LANE_ST-1];

  always_comb begin
    if (deg_l) begin
      rsp_d          = '0;
      rsp_d.rot_c0_x = ROT_ONE;
      rsp_d.rot_c1_y = ROT_ONE;
      rsp_d.rot_c2_z = ROT_ONE;
    end else begin
      rsp_d.rot_c0_x = sat_rot(quo[0]);
      rsp_d.rot_c0_y = sat_rot(quo[1]);
      rsp_d.rot_c0_z = sat_rot(quo[2]);
      rsp_d.rot_c1_x = sat_rot(quo[3]);
      rsp_d.rot_c1_y = sat_rot(quo[4]);
      rsp_d.rot_c1_z = sat_rot(quo[5]);
      rsp_d.rot_c2_x = sat_rot(quo[6]);
      rsp_d.rot_c2_y = sat_rot(quo[7]);
      rsp_d.rot_c2_z = sat_rot(quo[8]);
      rsp_d.trans_x  = sat_tr(quo[9]);
      rsp_d.trans_y  = sat_tr(quo[10]);
      rsp_d.trans_z  = sat_tr(quo[11]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = v_q[NST-1];
  assign out_rsp_o   = rsp_q;

  // ---- checks ----
  // An empty output stage must never block the request side.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request side blocked with empty output stage");

  // An accepted request must occupy the first stage on the next edge.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted request not captured");

  // The rotation entry rot_c1_x stays within plus or minus one.
  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_rsp_o.rot_c1_x) <= $signed(ROT_ONE)) &&
                    ($signed(out_rsp_o.rot_c1_x) >= -$signed(ROT_ONE)))
    else $error("rotation entry out of range");

endmodule

### tb/dqm_checker.sv
// Scoreboard for the dual quaternion to matrix block: predicts and compares responses.
`timescale 1ns / 1ps

module dqm_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  dqm_pkg::dqm_in_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  dqm_pkg::dqm_out_t out_rsp_i,
  output int                err_cnt_o,
  output int                pending_o,
  output int                rsp_cnt_o
);
  import dqm_pkg::*;

  dqm_out_t xform_q[$];

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic dqm_out_t calc_xform(dqm_in_t r);
    longint w, x, y, z, dw, dx, dy, dz, n;
    longint num[9];
    longint p[3];
    longint rot[9];
    longint tr[3];
    dqm_out_t o;
    w = r.real_w; x = r.real_x; y = r.real_y; z = r.real_z;
    dw = r.dual_w; dx = r.dual_x; dy = r.dual_y; dz = r.dual_z;
    n = w*w + x*x + y*y + z*z;
    if (n <= 268) begin
      foreach (rot[i]) rot[i] = 0;
      rot[0] = 16384; rot[4] = 16384; rot[8] = 16384;
      foreach (tr[i]) tr[i] = 0;
    end else begin
      num[0] = w*w + x*x - y*y - z*z;
      num[1] = 2 * (x*y + w*z);
      num[2] = 2 * (x*z - w*y);
      num[3] = 2 * (x*y - w*z);
      num[4] = w*w + y*y - x*x - z*z;
      num[5] = 2 * (y*z + w*x);
      num[6] = 2 * (x*z + w*y);
      num[7] = 2 * (y*z - w*x);
      num[8] = w*w + z*z - x*x - y*y;
      foreach (num[i]) rot[i] = clamp(round_div(num[i] * 16384, n), -16384, 16384);
      p[0] = w*dx - dw*x - (dy*z - dz*y);
      p[1] = w*dy - dw*y - (dz*x - dx*z);
      p[2] = w*dz - dw*z - (dx*y - dy*x);
      foreach (p[i]) tr[i] = clamp(round_div(p[i] * 32768, n), -524288, 524287);
    end
    o.rot_c0_x = 16'(rot[0]); o.rot_c0_y = 16'(rot[1]); o.rot_c0_z = 16'(rot[2]);
    o.rot_c1_x = 16'(rot[3]); o.rot_c1_y = 16'(rot[4]); o.rot_c1_z = 16'(rot[5]);
    o.rot_c2_x = 16'(rot[6]); o.rot_c2_y = 16'(rot[7]); o.rot_c2_z = 16'(rot[8]);
    o.trans_x = 20'(tr[0]); o.trans_y = 20'(tr[1]); o.trans_z = 20'(tr[2]);
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt_o++;
  endtask

  task automatic check_field(string what, longint got, longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  initial begin
    err_cnt_o = 0;
    rsp_cnt_o = 0;
  end

  assign pending_o = xform_q.size();

  always @(posedge clk_i) begin
    dqm_out_t e;
    dqm_out_t g;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) xform_q.push_back(calc_xform(in_req_i));
      if (out_valid_i && out_ready_i) begin
        rsp_cnt_o++;
        g = out_rsp_i;
        if (xform_q.size() == 0) begin
          report_mismatch("unexpected response", 1, 0);
        end else begin
          e = xform_q.pop_front();
          check_field("rot_c0_x", g.rot_c0_x, e.rot_c0_x);
          check_field("rot_c0_y", g.rot_c0_y, e.rot_c0_y);
          check_field("rot_c0_z", g.rot_c0_z, e.rot_c0_z);
          check_field("rot_c1_x", g.rot_c1_x, e.rot_c1_x);
          check_field("rot_c1_y", g.rot_c1_y, e.rot_c1_y);
          check_field("rot_c1_z", g.rot_c1_z, e.rot_c1_z);
          check_field("rot_c2_x", g.rot_c2_x, e.rot_c2_x);
          check_field("rot_c2_y", g.rot_c2_y, e.rot_c2_y);
          check_field("rot_c2_z", g.rot_c2_z, e.rot_c2_z);
          check_field("trans_x", g.trans_x, e.trans_x);
          check_field("trans_y", g.trans_y, e.trans_y);
          check_field("trans_z", g.trans_z, e.trans_z);
        end
      end
    end
  end
endmodule

### tb/dual_quaternion_to_matrix_top_tb.sv
// Testbench top: drives requests and back-pressure, gives the verdict.
`timescale 1ns / 1ps

module dual_quaternion_to_matrix_top_tb;
  import dqm_pkg::*;

  localparam int RAND_REQS = 500;
  // No progress for this many cycles means the pipeline is stuck.
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  dqm_in_t  in_req_i;
  logic     out_valid_o;
  logic     out_ready_i;
  dqm_out_t out_rsp_o;
  int       err_cnt;
  int       pending;
  int       rsp_cnt;
  int       idle_cycles;
  int       req_cnt;
  bit       stim_done;

  dual_quaternion_to_matrix_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  dqm_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_i  (out_rsp_o),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .rsp_cnt_o  (rsp_cnt)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rnd_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return 16'($urandom_range(0, 40)) - 16'd20;
    return 16'($urandom);
  endfunction

  // Present one request at the falling edge and hold it until it is taken.
  // Valid drops only for a gap, so back-to-back requests keep it high.
  task automatic send_req(dqm_in_t r);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    req_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_fields(int w, int x, int y, int z, int dw, int dx, int dy, int dz);
    dqm_in_t r;
    r.real_w = 16'(w); r.real_x = 16'(x); r.real_y = 16'(y); r.real_z = 16'(z);
    r.dual_w = 16'(dw); r.dual_x = 16'(dx); r.dual_y = 16'(dy); r.dual_z = 16'(dz);
    send_req(r);
  endtask

  // Receiver side: toggle ready with gaps and long stalls, plus calm stretches.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk_i);
      if ($urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap_len() + 1) @(negedge clk_i);
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    dqm_in_t r;
    idle_cycles = 0;
    req_cnt     = 0;
    stim_done   = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    rst_ni      = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: identity, degenerate norms around the threshold, extremes.
    send_fields(16384, 0, 0, 0, 0, 0, 0, 0);
    send_fields(0, 0, 0, 0, 100, -200, 300, -400);
    send_fields(16, 2, 0, 0, 1, 1, 1, 1);            // norm 260, degenerate
    send_fields(16, 2, 2, 0, 1, 1, 1, 1);            // norm 264, degenerate
    send_fields(16, 2, 2, 2, 1, 1, 1, 1);            // norm 268, on threshold
    send_fields(16, 3, 2, 1, 1, 1, 1, 1);            // just above threshold
    send_fields(1, 0, 0, 0, 32767, 32767, 32767, 32767);
    send_fields(17, 0, 0, 0, -32768, -32768, -32768, -32768);
    send_fields(-32768, -32768, -32768, -32768, 32767, -32768, 32767, -32768);
    send_fields(32767, 32767, 32767, 32767, -32768, 32767, -32768, 32767);
    send_fields(-32768, 0, 0, 0, 0, 256, 512, -768);
    send_fields(0, 16384, 0, 0, 0, 256, 0, 0);
    send_fields(0, 0, 16384, 0, 0, 0, 256, 0);
    send_fields(0, 0, 0, 16384, 0, 0, 0, 256);
    send_fields(11585, 11585, 0, 0, 0, 1000, -1000, 500);
    send_fields(20, 0, 0, 0, 32767, -32768, 32767, -32768); // translation clamps
    send_fields(0, 17, 0, 0, -32768, 32767, -32768, 32767);
    send_fields(-1, -1, -1, -1, -1, -1, -1, -1);

    // Random: mostly raw patterns, some with small real parts around the threshold.
    for (int i = 0; i < RAND_REQS; i++) begin
      r.real_w = rnd_word(); r.real_x = rnd_word();
      r.real_y = rnd_word(); r.real_z = rnd_word();
      r.dual_w = rnd_word(); r.dual_x = rnd_word();
      r.dual_y = rnd_word(); r.dual_z = rnd_word();
      if ($urandom_range(0, 3) == 0) begin
        r.real_w = 16'(int'($urandom_range(0, 32)) - 16);
        r.real_x = 16'(int'($urandom_range(0, 16)) - 8);
        r.real_y = 16'(int'($urandom_range(0, 16)) - 8);
        r.real_z = 16'(int'($urandom_range(0, 16)) - 8);
      end
      send_req(r);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;

    // Drain: wait for all responses, then let the pipeline settle.
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d dual quaternions, checked %0d transforms", req_cnt, rsp_cnt);
    $display("Covered degenerate norms, field extremes, clamping and random back-pressure");
    if (err_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
